// ----- hw/rtl/srld_pkg.sv -----
// Package for the sprite run-length decoder: parse phases, result kinds,
// error codes and the result word layout. No dependencies.
`default_nettype none

package srld_pkg;

   localparam int unsigned MAX_DIM_DEFAULT     = 512;
   localparam logic [9:0]  MAX_DIMENSION_RESET = 10'd500;

   localparam int unsigned TDATA_OUT_WIDTH = 96;
   localparam int unsigned RESULT_BITS     = 89;

   typedef enum logic [3:0] {
      PHASE_WAIT      = 4'd0,
      PHASE_RIGHT_LO  = 4'd1,
      PHASE_RIGHT_HI  = 4'd2,
      PHASE_LEFT_LO   = 4'd3,
      PHASE_LEFT_HI   = 4'd4,
      PHASE_TOP_LO    = 4'd5,
      PHASE_TOP_HI    = 4'd6,
      PHASE_BOTTOM_LO = 4'd7,
      PHASE_BOTTOM_HI = 4'd8,
      PHASE_SEG_LO    = 4'd9,
      PHASE_SEG_HI    = 4'd10,
      PHASE_X_LO      = 4'd11,
      PHASE_X_HI      = 4'd12,
      PHASE_Y_LO      = 4'd13,
      PHASE_Y_HI      = 4'd14,
      PHASE_BODY      = 4'd15
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXELS = 2'd1,
      KIND_END    = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   localparam logic [1:0] ERR_HEADER = 2'd0;
   localparam logic [1:0] ERR_BOUNDS = 2'd1;
   localparam logic [1:0] ERR_RUN    = 2'd2;

   typedef struct packed {
      logic [1:0]  error_code;
      logic [9:0]  frame_height;
      logic [9:0]  frame_width;
      logic [16:0] frame_top;
      logic [16:0] frame_left;
      logic [7:0]  color_index;
      logic [6:0]  run_length;
      logic [8:0]  row;
      logic [8:0]  column;
   } payload_type;

   typedef struct packed {
      kind_type    kind;
      payload_type payload;
   } result_type;

   // handshake between parser and output stage
   typedef struct packed {
      logic       fire;
      logic       result_valid;
   } stage_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sprite_run_length_decoder_core.sv -----
// An accepted req word goes through the input register, then is decoded into
// the result register (rsp_tvalid). Throughput: one byte per cycle while no
// rsp_tready stall holds the output; the phase and segment state update in the
// same cycle as the result register. Reset (synchronous, active high) empties
// both registers, sets the parser to wait for frame start, max_dimension to 500.
`default_nettype none

module sprite_run_length_decoder_core #(
   parameter int unsigned MAX_DIM = srld_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // tdata: data_byte
   input  wire logic [7:0]  req_tdata,
   // tuser: frame_start
   input  wire logic        req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: column, row, run_length, color_index, frame_left, frame_top,
   //        frame_width, frame_height, error_code, zero fill
   output      logic [srld_pkg::TDATA_OUT_WIDTH-1:0] rsp_tdata,
   // tuser: kind
   output      logic [1:0]  rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff, in_byte_in;
   logic                     in_start_ff, in_start_in;
   logic [9:0]               max_dimension;
   srld_pkg::result_type     result;
   logic                     result_valid;
   srld_pkg::stage_ctrl_type ctrl;

   assign req_tready = ~in_valid_ff | ctrl.fire;

   always_comb begin
      in_valid_in = in_valid_ff & ~ctrl.fire;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_tvalid & req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_start_in = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
   end

   srld_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .max_dimension (max_dimension)
   );

   srld_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (ctrl.fire),
      .data_byte     (in_byte_ff),
      .frame_start   (in_start_ff),
      .max_dimension (max_dimension),
      .result        (result),
      .result_valid  (result_valid)
   );

   srld_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .result       (result),
      .result_valid (result_valid),
      .ctrl         (ctrl),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/srld_csr.sv -----
// Configuration register block: APB-style access to max_dimension.
// Uses srld_pkg for the reset value.
`default_nettype none

module srld_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready,
   output      logic [9:0]  max_dimension
);

   logic [9:0] max_dim_ff;
   logic [9:0] max_dim_in;
   logic       write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];

   always_comb begin
      max_dim_in = max_dim_ff;
      if (write_hit) begin
         max_dim_in = csr_pwdata[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dim_ff <= srld_pkg::MAX_DIMENSION_RESET;
      end else begin
         max_dim_ff <= max_dim_in;
      end
   end

   assign csr_prdata    = csr_paddr[2] ? 32'd0 : {22'd0, max_dim_ff};
   assign max_dimension = max_dim_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/srld_parser.sv -----
// Frame parser: phase register, header and segment state, and the single-pass
// decode of one registered input byte into at most one result. Uses srld_pkg.
`default_nettype none

module srld_parser #(
   parameter int unsigned MAX_DIM = srld_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   frame_start,
   input  wire logic [9:0]             max_dimension,
   output      srld_pkg::result_type   result,
   output      logic                   result_valid
);

   localparam logic signed [18:0] MaxDimS = 19'(MAX_DIM);

   srld_pkg::phase_type phase_ff, phase_in, phase_eff;

   logic [7:0]         low_byte_ff,   low_byte_in;
   logic [15:0]        field_hold_ff, field_hold_in;
   logic signed [16:0] min_x_ff, min_x_in;
   logic signed [16:0] min_y_ff, min_y_in;
   logic signed [16:0] max_x_ff, max_x_in;
   logic signed [16:0] max_y_ff, max_y_in;
   logic [14:0]        seg_rem_ff, seg_rem_in, seg_rem_eff;
   logic               seg_is_run_ff, seg_is_run_in;
   logic [6:0]         run_rem_ff, run_rem_in, run_rem_eff;
   logic               repeat_ff, repeat_in, repeat_eff;
   logic [8:0]         write_col_ff, write_col_in;
   logic [8:0]         write_row_ff, write_row_in;

   logic [15:0]        word16;
   logic signed [18:0] word_s, x_s, min_x_s, min_y_s, max_x_s, max_y_s;
   logic signed [18:0] max_y_new, width_s, height_s, lim_s, seg_end_s, x_off, y_off;
   logic [16:0]        max_y_new_t;
   logic               hdr_bad, seg_bad, run_too_long;
   logic [6:0]         run_len;

   // restart abandons any partial frame
   always_comb begin
      phase_eff   = phase_ff;
      seg_rem_eff = seg_rem_ff;
      run_rem_eff = run_rem_ff;
      repeat_eff  = repeat_ff;
      if (frame_start) begin
         phase_eff   = srld_pkg::PHASE_RIGHT_LO;
         seg_rem_eff = '0;
         run_rem_eff = '0;
         repeat_eff  = 1'b0;
      end
   end

   assign word16  = {data_byte, low_byte_ff};
   assign word_s  = {{3{word16[15]}}, word16};
   assign x_s     = {{3{field_hold_ff[15]}}, field_hold_ff};
   assign min_x_s = {{2{min_x_ff[16]}}, min_x_ff};
   assign min_y_s = {{2{min_y_ff[16]}}, min_y_ff};
   assign max_x_s = {{2{max_x_ff[16]}}, max_x_ff};
   assign max_y_s = {{2{max_y_ff[16]}}, max_y_ff};

   assign max_y_new   = word_s + 19'sd1;
   assign max_y_new_t = max_y_new[16:0];
   assign width_s     = max_x_s - min_x_s;
   assign height_s    = max_y_new - min_y_s;
   assign lim_s       = {9'd0, max_dimension};
   assign hdr_bad     = (width_s <= 19'sd0) || (height_s <= 19'sd0) ||
                        (width_s > lim_s) || (height_s > lim_s) ||
                        (width_s > MaxDimS) || (height_s > MaxDimS);

   assign seg_end_s = x_s + {4'd0, seg_rem_eff};
   assign seg_bad   = (x_s < min_x_s) || (seg_end_s > max_x_s) ||
                      (word_s < min_y_s) || (word_s >= max_y_s);
   assign x_off     = x_s - min_x_s;
   assign y_off     = word_s - min_y_s;

   assign run_len      = data_byte[7:1];
   assign run_too_long = {8'd0, run_len} > seg_rem_eff;

   // datapath and result
   always_comb begin
      low_byte_in   = low_byte_ff;
      field_hold_in = field_hold_ff;
      min_x_in      = min_x_ff;
      min_y_in      = min_y_ff;
      max_x_in      = max_x_ff;
      max_y_in      = max_y_ff;
      seg_rem_in    = seg_rem_eff;
      seg_is_run_in = seg_is_run_ff;
      run_rem_in    = run_rem_eff;
      repeat_in     = repeat_eff;
      write_col_in  = write_col_ff;
      write_row_in  = write_row_ff;
      result        = '0;
      result_valid  = 1'b0;
      case (phase_eff)
         srld_pkg::PHASE_RIGHT_LO, srld_pkg::PHASE_LEFT_LO, srld_pkg::PHASE_TOP_LO,
         srld_pkg::PHASE_BOTTOM_LO, srld_pkg::PHASE_SEG_LO, srld_pkg::PHASE_X_LO,
         srld_pkg::PHASE_Y_LO: begin
            low_byte_in = data_byte;
         end
         srld_pkg::PHASE_RIGHT_HI: begin
            max_x_in = max_y_new_t;
         end
         srld_pkg::PHASE_LEFT_HI: begin
            min_x_in = 17'(-word_s);
         end
         srld_pkg::PHASE_TOP_HI: begin
            min_y_in = 17'(-word_s);
         end
         srld_pkg::PHASE_BOTTOM_HI: begin
            max_y_in     = max_y_new_t;
            result_valid = 1'b1;
            if (hdr_bad) begin
               result.kind               = srld_pkg::KIND_ERROR;
               result.payload.error_code = srld_pkg::ERR_HEADER;
            end else begin
               result.kind                 = srld_pkg::KIND_HEADER;
               result.payload.frame_left   = min_x_ff;
               result.payload.frame_top    = min_y_ff;
               result.payload.frame_width  = width_s[9:0];
               result.payload.frame_height = height_s[9:0];
            end
         end
         srld_pkg::PHASE_SEG_HI: begin
            if (word16 == 16'd0) begin
               result_valid = 1'b1;
               result.kind  = srld_pkg::KIND_END;
            end else begin
               seg_is_run_in = word16[0];
               seg_rem_in    = word16[15:1];
            end
         end
         srld_pkg::PHASE_X_HI: begin
            field_hold_in = word16;
         end
         srld_pkg::PHASE_Y_HI: begin
            if (seg_bad) begin
               result_valid              = 1'b1;
               result.kind               = srld_pkg::KIND_ERROR;
               result.payload.error_code = srld_pkg::ERR_BOUNDS;
            end else begin
               write_col_in = x_off[8:0];
               write_row_in = y_off[8:0];
               run_rem_in   = '0;
               repeat_in    = 1'b0;
            end
         end
         srld_pkg::PHASE_BODY: begin
            result.payload.column      = write_col_ff;
            result.payload.row         = write_row_ff;
            result.payload.color_index = data_byte;
            if (!seg_is_run_ff) begin
               result_valid              = 1'b1;
               result.kind               = srld_pkg::KIND_PIXELS;
               result.payload.run_length = 7'd1;
               write_col_in              = write_col_ff + 9'd1;
               seg_rem_in                = seg_rem_eff - 15'd1;
            end else if (repeat_eff) begin
               if (run_rem_eff != 7'd0) begin
                  result_valid              = 1'b1;
                  result.kind               = srld_pkg::KIND_PIXELS;
                  result.payload.run_length = run_rem_eff;
                  write_col_in              = write_col_ff + {2'd0, run_rem_eff};
               end
               run_rem_in = '0;
               repeat_in  = 1'b0;
            end else if (run_rem_eff != 7'd0) begin
               result_valid              = 1'b1;
               result.kind               = srld_pkg::KIND_PIXELS;
               result.payload.run_length = 7'd1;
               write_col_in              = write_col_ff + 9'd1;
               run_rem_in                = run_rem_eff - 7'd1;
            end else if (run_too_long) begin
               result_valid              = 1'b1;
               result.kind               = srld_pkg::KIND_ERROR;
               result.payload.error_code = srld_pkg::ERR_RUN;
            end else begin
               seg_rem_in = seg_rem_eff - {8'd0, run_len};
               run_rem_in = run_len;
               repeat_in  = data_byte[0];
            end
            // clear the write fields again when no pixels go out
            if (!result_valid || (result.kind != srld_pkg::KIND_PIXELS)) begin
               result.payload.column      = '0;
               result.payload.row         = '0;
               result.payload.color_index = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_eff;
      case (phase_eff)
         srld_pkg::PHASE_WAIT:      phase_in = srld_pkg::PHASE_WAIT;
         srld_pkg::PHASE_RIGHT_LO:  phase_in = srld_pkg::PHASE_RIGHT_HI;
         srld_pkg::PHASE_RIGHT_HI:  phase_in = srld_pkg::PHASE_LEFT_LO;
         srld_pkg::PHASE_LEFT_LO:   phase_in = srld_pkg::PHASE_LEFT_HI;
         srld_pkg::PHASE_LEFT_HI:   phase_in = srld_pkg::PHASE_TOP_LO;
         srld_pkg::PHASE_TOP_LO:    phase_in = srld_pkg::PHASE_TOP_HI;
         srld_pkg::PHASE_TOP_HI:    phase_in = srld_pkg::PHASE_BOTTOM_LO;
         srld_pkg::PHASE_BOTTOM_LO: phase_in = srld_pkg::PHASE_BOTTOM_HI;
         srld_pkg::PHASE_BOTTOM_HI: begin
            phase_in = hdr_bad ? srld_pkg::PHASE_WAIT : srld_pkg::PHASE_SEG_LO;
         end
         srld_pkg::PHASE_SEG_LO:    phase_in = srld_pkg::PHASE_SEG_HI;
         srld_pkg::PHASE_SEG_HI: begin
            phase_in = (word16 == 16'd0) ? srld_pkg::PHASE_WAIT : srld_pkg::PHASE_X_LO;
         end
         srld_pkg::PHASE_X_LO:      phase_in = srld_pkg::PHASE_X_HI;
         srld_pkg::PHASE_X_HI:      phase_in = srld_pkg::PHASE_Y_LO;
         srld_pkg::PHASE_Y_LO:      phase_in = srld_pkg::PHASE_Y_HI;
         srld_pkg::PHASE_Y_HI: begin
            if (seg_bad) begin
               phase_in = srld_pkg::PHASE_WAIT;
            end else if (seg_rem_eff == 15'd0) begin
               phase_in = srld_pkg::PHASE_SEG_LO;
            end else begin
               phase_in = srld_pkg::PHASE_BODY;
            end
         end
         srld_pkg::PHASE_BODY: begin
            if (seg_is_run_ff && !repeat_eff && (run_rem_eff == 7'd0) && run_too_long) begin
               phase_in = srld_pkg::PHASE_WAIT;
            end else if ((seg_rem_in == 15'd0) && (run_rem_in == 7'd0) && !repeat_in) begin
               phase_in = srld_pkg::PHASE_SEG_LO;
            end else begin
               phase_in = srld_pkg::PHASE_BODY;
            end
         end
         default: phase_in = srld_pkg::PHASE_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= srld_pkg::PHASE_WAIT;
         low_byte_ff   <= '0;
         field_hold_ff <= '0;
         min_x_ff      <= '0;
         min_y_ff      <= '0;
         max_x_ff      <= '0;
         max_y_ff      <= '0;
         seg_rem_ff    <= '0;
         seg_is_run_ff <= 1'b0;
         run_rem_ff    <= '0;
         repeat_ff     <= 1'b0;
         write_col_ff  <= '0;
         write_row_ff  <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         low_byte_ff   <= low_byte_in;
         field_hold_ff <= field_hold_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         seg_rem_ff    <= seg_rem_in;
         seg_is_run_ff <= seg_is_run_in;
         run_rem_ff    <= run_rem_in;
         repeat_ff     <= repeat_in;
         write_col_ff  <= write_col_in;
         write_row_ff  <= write_row_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/srld_out_stage.sv -----
// Result register with stream handshake; it tells the parser when a word may
// advance. Uses srld_pkg for the result layout.
`default_nettype none

module srld_out_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire srld_pkg::result_type              result,
   input  wire logic                              result_valid,
   output      srld_pkg::stage_ctrl_type          ctrl,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: column, row, run_length, color_index, frame_left, frame_top,
   //        frame_width, frame_height, error_code, zero fill
   output      logic [srld_pkg::TDATA_OUT_WIDTH-1:0] rsp_tdata,
   // tuser: kind
   output      logic [1:0]                        rsp_tuser
);

   logic                 valid_ff, valid_in;
   srld_pkg::result_type data_ff, data_in;
   logic                 advance;

   // output slot free or emptying this cycle
   assign advance           = ~valid_ff | rsp_tready;
   assign ctrl.fire         = in_valid & advance;
   assign ctrl.result_valid = result_valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = ctrl.fire & result_valid;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tdata  = {(srld_pkg::TDATA_OUT_WIDTH - srld_pkg::RESULT_BITS)'(0),
                        data_ff.payload};

endmodule

`default_nettype wire
